// File: hdl/bounded_stack_with_sort_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bounded stack with sort unit
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_STACK_WITH_SORT_UNIT_DEFINES_SVH
`define BOUNDED_STACK_WITH_SORT_UNIT_DEFINES_SVH

// same-cycle implication
`define BSWS_AST_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bsws assertion failed");

// next-cycle implication
`define BSWS_AST_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bsws assertion failed");

`endif

// File: hdl/bsws_pkg.sv
// ----------------------------------------------------------------------------
// bsws_pkg
// Shared sizes, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package bsws_pkg;

	localparam int DEPTH      = 8;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W      = $clog2(DEPTH);
	localparam int CNT_W      = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		OP_PUSH = 2'd0,
		OP_POP  = 2'd1,
		OP_DUMP = 2'd2,
		OP_SORT = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		OUT_PUSH,
		OUT_FULL,
		OUT_EMPTY,
		OUT_POP,
		OUT_DUMP
	} out_kind_t;

	typedef enum logic [1:0] {
		RA_TOP,
		RA_I,
		RA_J
	} ra_sel_t;

	typedef enum logic [1:0] {
		WA_TOP,
		WA_I,
		WA_J
	} wa_sel_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISP,
		S_PUSH,
		S_POP,
		S_EMPTY,
		S_DUMP_RD,
		S_DUMP_OUT,
		S_SORT_LD,
		S_SORT_CUR,
		S_SORT_RD,
		S_SORT_CMP,
		S_SORT_WB
	} state_t;

	typedef struct packed {
		logic      load;
		logic      wr_en;
		wa_sel_t   wa_sel;
		ra_sel_t   ra_sel;
		logic      cnt_inc;
		logic      cnt_dec;
		logic      i_clr;
		logic      i_inc;
		logic      j_from_i;
		logic      j_inc;
		logic      cur_from_rd;
		logic      out_load;
		out_kind_t out_kind;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic empty;
		logic full;
		logic i_last;
		logic j_last;
		logic less;
		logic out_free;
	} stat_t;

endpackage

`default_nettype wire

// File: hdl/bounded_stack_with_sort_unit.sv
// ----------------------------------------------------------------------------
// bounded_stack_with_sort_unit
// Eight-deep stack of signed 32-bit words with pop, dump and exchange sort.
//
//   channel | handshake           | payload
//   --------+---------------------+-------------------------------------
//   in      | in_valid / in_ready | op, value
//   out     | out_valid/out_ready | status, data, index, count, last
//
// Steps per request:
//   push, pop, empty cases: accept, decode, result load.
//   dump: accept, decode; every element takes a memory read then a result load.
//   sort: accept, decode; each slot below the top takes load, latch, a read and
//   compare per later slot, then write-back; the top slot only loads and
//   latches; the dump follows, walked by the single read port.
// One request is in flight at a time; in_ready is high only when idle.
// Reset clears fill count, sequencer and result valid; stack words stay
// unknown until pushed. A stalled result holds the sequencer in place.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_stack_with_sort_unit (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [1:0]                             op,
	input  logic signed [bsws_pkg::DATA_WIDTH-1:0] value,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [1:0]                             status,
	output logic signed [bsws_pkg::DATA_WIDTH-1:0] data,
	output logic [bsws_pkg::IDX_W-1:0]             index,
	output logic [bsws_pkg::CNT_W-1:0]             count,
	output logic                                   last
);
	import bsws_pkg::*;

	// commands down to the datapath, status back to the sequencer
	cmd_t  cmd;
	stat_t stat;

	// sequencer: decodes the request and steps through its phases
	bsws_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// datapath: stack memory, counters, sort word and result register
	bsws_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op),
		.value     (value),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.data      (data),
		.index     (index),
		.count     (count),
		.last      (last)
	);

endmodule

`default_nettype wire

// File: hdl/bsws_ctrl.sv
// ----------------------------------------------------------------------------
// bsws_ctrl
// Request sequencer: push, pop, dump and exchange sort walk.
// ----------------------------------------------------------------------------
`default_nettype none

module bsws_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  bsws_pkg::stat_t stat,
	output bsws_pkg::cmd_t  cmd
);
	import bsws_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		in_ready  = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = S_DISP;
				end
			end
			S_DISP: begin
				case (stat.op)
					OP_PUSH: begin
						state_nxt = S_PUSH;
					end
					OP_POP: begin
						cmd.ra_sel = RA_TOP;
						state_nxt  = stat.empty ? S_EMPTY : S_POP;
					end
					OP_DUMP: begin
						cmd.i_clr = 1'b1;
						state_nxt = stat.empty ? S_EMPTY : S_DUMP_RD;
					end
					OP_SORT: begin
						cmd.i_clr = 1'b1;
						state_nxt = stat.empty ? S_EMPTY : S_SORT_LD;
					end
					default: begin
						state_nxt = S_IDLE;
					end
				endcase
			end
			S_PUSH: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					if (stat.full) begin
						cmd.out_kind = OUT_FULL;
					end else begin
						cmd.out_kind = OUT_PUSH;
						cmd.wr_en    = 1'b1;
						cmd.wa_sel   = WA_TOP;
						cmd.cnt_inc  = 1'b1;
					end
					state_nxt = S_IDLE;
				end
			end
			S_POP: begin
				cmd.ra_sel = RA_TOP;
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_kind = OUT_POP;
					cmd.cnt_dec  = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			S_EMPTY: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_kind = OUT_EMPTY;
					state_nxt    = S_IDLE;
				end
			end
			S_DUMP_RD: begin
				cmd.ra_sel = RA_I;
				state_nxt  = S_DUMP_OUT;
			end
			S_DUMP_OUT: begin
				cmd.ra_sel = RA_I;
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_kind = OUT_DUMP;
					if (stat.i_last) begin
						state_nxt = S_IDLE;
					end else begin
						cmd.i_inc = 1'b1;
						state_nxt = S_DUMP_RD;
					end
				end
			end
			S_SORT_LD: begin
				cmd.ra_sel = RA_I;
				state_nxt  = S_SORT_CUR;
			end
			S_SORT_CUR: begin
				cmd.cur_from_rd = 1'b1;
				cmd.j_from_i    = 1'b1;
				if (stat.i_last) begin
					// outer walk done, dump the sorted contents
					cmd.i_clr = 1'b1;
					state_nxt = S_DUMP_RD;
				end else begin
					state_nxt = S_SORT_RD;
				end
			end
			S_SORT_RD: begin
				cmd.ra_sel = RA_J;
				state_nxt  = S_SORT_CMP;
			end
			S_SORT_CMP: begin
				if (stat.less) begin
					cmd.wr_en       = 1'b1;
					cmd.wa_sel      = WA_J;
					cmd.cur_from_rd = 1'b1;
				end
				if (stat.j_last) begin
					state_nxt = S_SORT_WB;
				end else begin
					cmd.j_inc = 1'b1;
					state_nxt = S_SORT_RD;
				end
			end
			S_SORT_WB: begin
				cmd.wr_en  = 1'b1;
				cmd.wa_sel = WA_I;
				cmd.i_inc  = 1'b1;
				state_nxt  = S_SORT_LD;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: hdl/bsws_dp.sv
// ----------------------------------------------------------------------------
// bsws_dp
// Stack memory, fill count, walk indexes, sort holding word, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bsws_dp (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic [1:0]                             op,
	input  logic signed [bsws_pkg::DATA_WIDTH-1:0] value,
	input  bsws_pkg::cmd_t                         cmd,
	output bsws_pkg::stat_t                        stat,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [1:0]                             status,
	output logic signed [bsws_pkg::DATA_WIDTH-1:0] data,
	output logic [bsws_pkg::IDX_W-1:0]             index,
	output logic [bsws_pkg::CNT_W-1:0]             count,
	output logic                                   last
);
	import bsws_pkg::*;

	logic signed [DATA_WIDTH-1:0] mem_q [DEPTH];
	logic signed [DATA_WIDTH-1:0] rd_q;
	logic signed [DATA_WIDTH-1:0] value_q;
	logic signed [DATA_WIDTH-1:0] cur_q;
	op_t                          op_q;
	logic [CNT_W-1:0]             cnt_q;
	logic [IDX_W-1:0]             i_q;
	logic [IDX_W-1:0]             j_q;
	logic                         out_valid_q;
	status_t                      status_q;
	logic signed [DATA_WIDTH-1:0] data_q;
	logic [IDX_W-1:0]             index_q;
	logic [CNT_W-1:0]             count_q;
	logic                         last_q;

	logic [CNT_W-1:0]             cnt_m1;
	logic [CNT_W-1:0]             cnt_p1;
	logic [IDX_W-1:0]             top_idx;
	logic [IDX_W-1:0]             raddr;
	logic [IDX_W-1:0]             waddr;
	logic signed [DATA_WIDTH-1:0] wdata;
	logic                         i_last;
	logic                         out_free;

	status_t                      e_status;
	logic signed [DATA_WIDTH-1:0] e_data;
	logic [IDX_W-1:0]             e_index;
	logic [CNT_W-1:0]             e_count;
	logic                         e_last;

	assign cnt_m1  = cnt_q - CNT_W'(1);
	assign cnt_p1  = cnt_q + CNT_W'(1);
	assign top_idx = cnt_m1[IDX_W-1:0];
	assign i_last  = (CNT_W'(i_q) + CNT_W'(1)) == cnt_q;
	assign out_free = !out_valid_q || out_ready;

	assign stat.op       = op_q;
	assign stat.empty    = cnt_q == '0;
	assign stat.full     = cnt_q == CNT_W'(DEPTH);
	assign stat.i_last   = i_last;
	assign stat.j_last   = (CNT_W'(j_q) + CNT_W'(1)) == cnt_q;
	assign stat.less     = rd_q < cur_q;
	assign stat.out_free = out_free;

	// request latch
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= op_t'(op);
			value_q <= value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.cnt_inc) begin
			cnt_q <= cnt_p1;
		end else if (cmd.cnt_dec) begin
			cnt_q <= cnt_m1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.i_clr) begin
			i_q <= '0;
		end else if (cmd.i_inc) begin
			i_q <= i_q + IDX_W'(1);
		end
		if (cmd.j_from_i) begin
			j_q <= i_q + IDX_W'(1);
		end else if (cmd.j_inc) begin
			j_q <= j_q + IDX_W'(1);
		end
		if (cmd.cur_from_rd) begin
			cur_q <= rd_q;
		end
	end

	// memory ports
	always_comb begin
		case (cmd.ra_sel)
			RA_TOP:  raddr = top_idx;
			RA_I:    raddr = i_q;
			RA_J:    raddr = j_q;
			default: raddr = i_q;
		endcase
		case (cmd.wa_sel)
			WA_TOP: begin
				waddr = cnt_q[IDX_W-1:0];
				wdata = value_q;
			end
			WA_I: begin
				waddr = i_q;
				wdata = cur_q;
			end
			WA_J: begin
				waddr = j_q;
				wdata = cur_q;
			end
			default: begin
				waddr = i_q;
				wdata = cur_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem_q[waddr] <= wdata;
		end
		rd_q <= mem_q[raddr];
	end

	// result formatting
	always_comb begin
		e_status = ST_OK;
		e_data   = '0;
		e_index  = '0;
		e_count  = '0;
		e_last   = 1'b1;
		case (cmd.out_kind)
			OUT_PUSH: begin
				e_data  = value_q;
				e_index = cnt_q[IDX_W-1:0];
				e_count = cnt_p1;
			end
			OUT_FULL: begin
				e_status = ST_FULL;
				e_count  = cnt_q;
			end
			OUT_EMPTY: begin
				e_status = ST_EMPTY;
			end
			OUT_POP: begin
				e_data  = rd_q;
				e_index = top_idx;
				e_count = cnt_m1;
			end
			OUT_DUMP: begin
				e_data  = rd_q;
				e_index = i_q;
				e_count = cnt_q;
				e_last  = i_last;
			end
			default: begin
				e_status = ST_EMPTY;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			status_q <= e_status;
			data_q   <= e_data;
			index_q  <= e_index;
			count_q  <= e_count;
			last_q   <= e_last;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign data      = data_q;
	assign index     = index_q;
	assign count     = count_q;
	assign last      = last_q;

endmodule

`default_nettype wire

// File: hdl/bsws_chk.sv
// ----------------------------------------------------------------------------
// bsws_chk
// Port-level checks for the bounded stack with sort unit, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bounded_stack_with_sort_unit_defines.svh"

module bsws_chk (
	input logic                                   clk,
	input logic                                   arst_n,
	input logic                                   in_valid,
	input logic                                   in_ready,
	input logic                                   out_valid,
	input logic                                   out_ready,
	input logic [1:0]                             status,
	input logic signed [bsws_pkg::DATA_WIDTH-1:0] data,
	input logic [bsws_pkg::IDX_W-1:0]             index,
	input logic [bsws_pkg::CNT_W-1:0]             count,
	input logic                                   last
);
	import bsws_pkg::*;

	// stalled result holds
	`BSWS_AST_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(data) && $stable(status) && $stable(index) && $stable(last))

	// a full report is single and shows a full stack
	`BSWS_AST_IMP(a_full_cnt, out_valid && status == ST_FULL, count == CNT_W'(DEPTH) && last)

	// only one request in flight
	`BSWS_AST_NXT(a_one_req, in_valid && in_ready, !in_ready)

	// more results pending keeps the input closed
	`BSWS_AST_IMP(a_busy_mid, out_valid && !last, !in_ready)

endmodule

bind bounded_stack_with_sort_unit bsws_chk u_chk (.*);

`default_nettype wire
